// ===== rtl/three_component_rms_agc_core_defines.svh =====
// Assertion macros for the RMS gain control RTL, used by the controller.
`ifndef THREE_COMPONENT_RMS_AGC_CORE_DEFINES_SVH
`define THREE_COMPONENT_RMS_AGC_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AGC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("agc assertion failed");
`define AGC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("agc assertion failed");
`else
`define AGC_ASSERT(label, clk, rst_n, prop)
`define AGC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/agc_pkg.sv =====
// Package with constants and controller/datapath types for the RMS gain control.
`timescale 1ns / 1ps
package agc_pkg;
  localparam int SampleBits   = 24;
  localparam int HalfBits     = 6;
  localparam int PtrBits      = 7;
  localparam int SumBits      = 56;
  localparam int GainBits     = 32;
  localparam int ProdBits     = 56;
  localparam int DivBits      = 57;
  localparam int RootBits     = 58;
  localparam int DivSteps     = 57;
  localparam int RootSteps    = 29;
  localparam logic [HalfBits-1:0] HalfReset = 6'd8;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_gain;
    logic [1:0] mul_k;
    logic       e_clr;
    logic       e_acc;
    logic       sum_add;
    logic       sum_sub;
    logic       rd_drop;
    logic       rd_emit;
    logic       s_from_rd;
    logic       div_init;
    logic       div_step;
    logic       root_init;
    logic       root_step;
    logic       gain_calc;
    logic       gain_hold;
    logic       sc_wr;
    logic [1:0] sc_k;
    logic       publish;
    logic       last;
    logic       clear;
  } agc_cmd_t;

  typedef struct packed {
    logic end_flag;
    logic pend_gt_h;
    logic pend_zero;
    logic pend_one;
    logic drop_due;
    logic sum_zero;
  } agc_stat_t;
endpackage

// ===== rtl/agc_if.sv =====
// Valid/ready channel interfaces for samples in and scaled results out.
`timescale 1ns / 1ps
interface agc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] comp_x;
  logic [23:0] comp_y;
  logic [23:0] comp_z;
  logic        trace_end;
  modport source (output valid, comp_x, comp_y, comp_z, trace_end, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, trace_end, output ready);
endinterface

interface agc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] scaled_x;
  logic [23:0] scaled_y;
  logic [23:0] scaled_z;
  logic [31:0] gain_value;
  logic        last_out;
  modport source (output valid, scaled_x, scaled_y, scaled_z, gain_value, last_out,
                  input ready);
  modport sink (input valid, scaled_x, scaled_y, scaled_z, gain_value, last_out,
                output ready);
endinterface

// ===== rtl/agc_datapath.sv =====
// Datapath: delay line memory, window sums, divider, square root and scaling.
`timescale 1ns / 1ps
module agc_datapath
  import agc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [HalfBits-1:0]   cfg_wr_data,
  input  logic [SampleBits-1:0] in_x,
  input  logic [SampleBits-1:0] in_y,
  input  logic [SampleBits-1:0] in_z,
  input  logic                  in_end,
  input  agc_cmd_t              cmd,
  output agc_stat_t             stat,
  output logic [SampleBits-1:0] res_x,
  output logic [SampleBits-1:0] res_y,
  output logic [SampleBits-1:0] res_z,
  output logic [GainBits-1:0]   res_gain,
  output logic                  res_last
);
  logic [3*SampleBits-1:0] line_mem [2**PtrBits];
  logic [3*SampleBits-1:0] rd_r;
  logic [SampleBits-1:0]   s_r [3];
  logic [SampleBits-1:0]   sc_r [3];
  logic [ProdBits-1:0]     prod_r;
  logic [SumBits-1:0]      e_r;
  logic [SumBits-1:0]      sum_r;
  logic [PtrBits-1:0]      wc_r, seen_r, emit_r;
  logic [GainBits-1:0]     held_r, gain_r;
  logic [HalfBits-1:0]     cfg_h_r, h_r;
  logic                    open_r, end_r;
  logic [DivBits-1:0]      rem_r, num_r;
  logic [DivBits-1:0]      root_v_r;
  logic [RootBits-1:0]     root_r, bit_r;

  logic [PtrBits-1:0]      pend, back, rd_addr;
  logic [SampleBits-1:0]   mul_a;
  logic [GainBits-1:0]     mul_b;
  logic [DivBits-1:0]      div_t;
  logic [8:0]              wc3;
  logic [RootBits-1:0]     root_t;
  logic [ProdBits-1:0]     rnd_sum;
  logic [ProdBits-7:0]     rnd;
  logic [SampleBits-1:0]   sc_val;

  function automatic logic [SampleBits-1:0] mag(input logic [SampleBits-1:0] s);
    mag = s[SampleBits-1] ? (~s + 1'b1) : s;
  endfunction

  assign pend    = seen_r - emit_r;
  assign back    = wc_r - pend;
  assign rd_addr = cmd.rd_drop ? (seen_r - wc_r) : emit_r;
  assign mul_a   = mag(s_r[cmd.mul_k]);
  assign mul_b   = cmd.mul_gain ? gain_r : {8'd0, mul_a};
  assign div_t   = {rem_r[DivBits-2:0], num_r[DivBits-1]};
  assign wc3     = {2'd0, wc_r} + {1'b0, wc_r, 1'b0};
  assign root_t  = root_r + bit_r;

  // Round half away from zero on the magnitude, then saturate to Q5.18.
  always_comb begin
    rnd_sum = prod_r + ProdBits'(32);
    rnd     = rnd_sum[ProdBits-1:6];
    if (s_r[cmd.sc_k][SampleBits-1]) begin
      if (rnd > 50'd8388608) sc_val = 24'h800000;
      else sc_val = ~rnd[SampleBits-1:0] + 1'b1;
    end else begin
      if (rnd > 50'd8388607) sc_val = 24'h7FFFFF;
      else sc_val = rnd[SampleBits-1:0];
    end
  end

  always_comb begin
    stat.end_flag  = end_r;
    stat.pend_gt_h = pend > {1'b0, h_r};
    stat.pend_zero = pend == '0;
    stat.pend_one  = pend == PtrBits'(1);
    stat.drop_due  = (wc_r > pend) && (back > {1'b0, h_r});
    stat.sum_zero  = sum_r == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) line_mem[seen_r] <= {in_x, in_y, in_z};
    if (cmd.rd_drop || cmd.rd_emit) rd_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r[0] <= in_x;
      s_r[1] <= in_y;
      s_r[2] <= in_z;
    end else if (cmd.s_from_rd) begin
      s_r[0] <= rd_r[3*SampleBits-1:2*SampleBits];
      s_r[1] <= rd_r[2*SampleBits-1:SampleBits];
      s_r[2] <= rd_r[SampleBits-1:0];
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.e_clr) e_r <= '0;
    else if (cmd.e_acc) e_r <= e_r + prod_r;
    if (cmd.sc_wr) sc_r[cmd.sc_k] <= sc_val;
    if (cmd.div_init) begin
      rem_r <= '0;
      num_r <= {wc3, 48'd0};
    end else if (cmd.div_step) begin
      if (div_t >= {1'b0, sum_r}) begin
        rem_r <= div_t - {1'b0, sum_r};
        num_r <= {num_r[DivBits-2:0], 1'b1};
      end else begin
        rem_r <= div_t;
        num_r <= {num_r[DivBits-2:0], 1'b0};
      end
    end
    if (cmd.root_init) begin
      root_v_r <= num_r;
      root_r   <= '0;
      bit_r    <= RootBits'(1) << 56;
    end else if (cmd.root_step) begin
      if ({1'b0, root_v_r} >= root_t) begin
        root_v_r <= root_v_r - root_t[DivBits-1:0];
        root_r   <= (root_r >> 1) + bit_r;
      end else begin
        root_r   <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.publish) begin
      res_x    <= sc_r[0];
      res_y    <= sc_r[1];
      res_z    <= sc_r[2];
      res_gain <= gain_r;
      res_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_h_r <= HalfReset;
      h_r     <= HalfReset;
      open_r  <= 1'b0;
      end_r   <= 1'b0;
      sum_r   <= '0;
      wc_r    <= '0;
      seen_r  <= '0;
      emit_r  <= '0;
      held_r  <= '0;
      gain_r  <= '0;
    end else begin
      if (cfg_wr_en) cfg_h_r <= cfg_wr_data;
      if (cmd.load) begin
        if (!open_r) h_r <= cfg_h_r;
        open_r <= 1'b1;
        end_r  <= in_end;
        wc_r   <= wc_r + 1'b1;
        seen_r <= seen_r + 1'b1;
      end
      if (cmd.sum_add) sum_r <= sum_r + e_r;
      if (cmd.sum_sub) begin
        sum_r <= sum_r - e_r;
        wc_r  <= wc_r - 1'b1;
      end
      if (cmd.gain_calc) begin
        gain_r <= (|root_r[RootBits-1:GainBits]) ? '1 : root_r[GainBits-1:0];
        held_r <= (|root_r[RootBits-1:GainBits]) ? '1 : root_r[GainBits-1:0];
      end else if (cmd.gain_hold) begin
        gain_r <= held_r;
      end
      if (cmd.publish) emit_r <= emit_r + 1'b1;
      if (cmd.clear) begin
        sum_r  <= '0;
        wc_r   <= '0;
        seen_r <= '0;
        emit_r <= '0;
        held_r <= '0;
        open_r <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/agc_ctrl.sv =====
// Controller state machine that sequences the datapath for each transaction.
`timescale 1ns / 1ps
`include "three_component_rms_agc_core_defines.svh"
module agc_ctrl
  import agc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  agc_stat_t stat,
  output agc_cmd_t  cmd
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_SQ0  = 5'd1,  S_SQ1  = 5'd2,  S_SQ2 = 5'd3;
  localparam logic [4:0] S_SQA  = 5'd4,  S_SADD = 5'd5,  S_SSUB = 5'd6,  S_DEC = 5'd7;
  localparam logic [4:0] S_DCHK = 5'd8,  S_DLD  = 5'd9,  S_ERD  = 5'd10, S_ELD = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12, S_RTI  = 5'd13, S_RT   = 5'd14, S_GN  = 5'd15;
  localparam logic [4:0] S_SC0  = 5'd16, S_SC1  = 5'd17, S_SC2  = 5'd18, S_SC3 = 5'd19;
  localparam logic [4:0] S_PUB  = 5'd20, S_POST = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       sub_r, sub_nxt, flush_r, flush_nxt, ov_r, ov_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sub_nxt   = sub_r;
    flush_nxt = flush_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        sub_nxt   = 1'b0;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        cmd.mul_en = 1'b1; cmd.mul_k = 2'd0; cmd.e_clr = 1'b1; state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.mul_en = 1'b1; cmd.mul_k = 2'd1; cmd.e_acc = 1'b1; state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.mul_en = 1'b1; cmd.mul_k = 2'd2; cmd.e_acc = 1'b1; state_nxt = S_SQA;
      end
      S_SQA: begin
        cmd.e_acc = 1'b1;
        state_nxt = sub_r ? S_SSUB : S_SADD;
      end
      S_SADD: begin
        cmd.sum_add = 1'b1; state_nxt = S_DEC;
      end
      S_DEC: begin
        if (stat.pend_gt_h) begin
          flush_nxt = 1'b0; state_nxt = S_DCHK;
        end else if (stat.end_flag) begin
          flush_nxt = 1'b1; state_nxt = S_DCHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DCHK: begin
        if (stat.drop_due) begin
          cmd.rd_drop = 1'b1; state_nxt = S_DLD;
        end else begin
          cmd.rd_emit = 1'b1; state_nxt = S_ELD;
        end
      end
      S_DLD: begin
        cmd.s_from_rd = 1'b1; sub_nxt = 1'b1; state_nxt = S_SQ0;
      end
      S_SSUB: begin
        cmd.sum_sub = 1'b1; state_nxt = S_ERD;
      end
      S_ERD: begin
        cmd.rd_emit = 1'b1; state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd.s_from_rd = 1'b1;
        if (stat.sum_zero) begin
          cmd.gain_hold = 1'b1; state_nxt = S_SC0;
        end else begin
          cmd.div_init = 1'b1; cnt_nxt = '0; state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == 6'(DivSteps - 1)) state_nxt = S_RTI;
      end
      S_RTI: begin
        cmd.root_init = 1'b1; cnt_nxt = '0; state_nxt = S_RT;
      end
      S_RT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == 6'(RootSteps - 1)) state_nxt = S_GN;
      end
      S_GN: begin
        cmd.gain_calc = 1'b1; state_nxt = S_SC0;
      end
      S_SC0: begin
        cmd.mul_en = 1'b1; cmd.mul_gain = 1'b1; cmd.mul_k = 2'd0; state_nxt = S_SC1;
      end
      S_SC1: begin
        cmd.mul_en = 1'b1; cmd.mul_gain = 1'b1; cmd.mul_k = 2'd1;
        cmd.sc_wr = 1'b1; cmd.sc_k = 2'd0; state_nxt = S_SC2;
      end
      S_SC2: begin
        cmd.mul_en = 1'b1; cmd.mul_gain = 1'b1; cmd.mul_k = 2'd2;
        cmd.sc_wr = 1'b1; cmd.sc_k = 2'd1; state_nxt = S_SC3;
      end
      S_SC3: begin
        cmd.sc_wr = 1'b1; cmd.sc_k = 2'd2; state_nxt = S_PUB;
      end
      S_PUB: if (!ov_r || out_ready) begin
        cmd.publish = 1'b1;
        cmd.last    = flush_r && stat.pend_one;
        ov_nxt      = 1'b1;
        state_nxt   = S_POST;
      end
      S_POST: begin
        if (stat.end_flag && !stat.pend_zero) begin
          flush_nxt = 1'b1; state_nxt = S_DCHK;
        end else if (stat.end_flag) begin
          cmd.clear = 1'b1; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sub_r   <= 1'b0;
      flush_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      flush_r <= flush_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // A waiting result is never overwritten by the next one.
  `AGC_ASSERT(a_no_overwrite, clk, rst_n, (ov_r && !out_ready) |-> !cmd.publish)
  // An accepted transaction always starts the squaring sequence.
  `AGC_ASSERT(a_accept_seq, clk, rst_n, (in_valid && in_ready) |=> state_r == S_SQ0)
  // The divider hands over to the square root after its last step.
  `AGC_ASSERT(a_div_done, clk, rst_n,
              (state_r == S_DIV && cnt_r == 6'(DivSteps - 1)) |=> state_r == S_RTI)
  // A publish always raises valid on the next cycle.
  `AGC_ASSERT(a_pub_valid, clk, rst_n, cmd.publish |=> ov_r)
endmodule

// ===== rtl/three_component_rms_agc_core.sv =====
// Top level of the three-component sliding-RMS automatic gain control.
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Content
// in_ch     in         valid/ready    comp_x, comp_y, comp_z, trace_end
// out_ch    out        valid/ready    scaled_x/y/z, gain_value, last_out
// cfg_*     in         write enable   half_window, 6 bits
//
// An input transaction folds into the window sum via the load, squaring, accumulate
// and add states. A result with nonzero window energy is dominated by the 57-step
// restoring divider and the 29-step square root, which a zero-energy result skips;
// dropping the oldest sample first squares and subtracts it. A trace_end transaction
// drains every pending result in turn, and no input is taken while results are made.
// Reset (synchronous, rst_n low) clears the window and trace state; the delay
// line memory needs no clearing. A stalled output only holds the controller
// when a second result is ready while the first still waits in the register.
module three_component_rms_agc_core
  import agc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  agc_in_if.sink        in_ch,
  agc_out_if.source     out_ch,
  input  logic          cfg_wr_en,
  input  logic [5:0]    cfg_wr_data
);
  agc_cmd_t  cmd;
  agc_stat_t stat;

  // The controller only sequences; all arithmetic and storage live in the datapath.
  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  agc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_x        (in_ch.comp_x),
    .in_y        (in_ch.comp_y),
    .in_z        (in_ch.comp_z),
    .in_end      (in_ch.trace_end),
    .cmd         (cmd),
    .stat        (stat),
    .res_x       (out_ch.scaled_x),
    .res_y       (out_ch.scaled_y),
    .res_z       (out_ch.scaled_z),
    .res_gain    (out_ch.gain_value),
    .res_last    (out_ch.last_out)
  );
endmodule
